FILE: rtl/msp_pkg.sv
// shared types, codes and helpers for the music command stream player
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_TICK  = 3'd1,
    OP_PLAY  = 3'd2,
    OP_PAUSE = 3'd3,
    OP_STOP  = 3'd4,
    OP_LOAD  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_SND     = 3'd0,
    K_FM      = 3'd1,
    K_FETCH   = 3'd2,
    K_END     = 3'd3,
    K_SILENCE = 3'd4,
    K_REWIND  = 3'd5
  } kind_e;

  localparam logic [1:0] ST_NOSONG  = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_PLAYING = 2'd2;
  localparam logic [1:0] ST_PAUSED  = 2'd3;

  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_SND   = 2'd1;
  localparam logic [1:0] PH_FMREG = 2'd2;
  localparam logic [1:0] PH_FMDAT = 2'd3;

  localparam logic [7:0] PSG_BASE_RST = 8'hC0;
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] stream_byte;
    logic       header_valid;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] addr, logic [7:0] data);
    res_t r;
    r.kind     = kind;
    r.reg_addr = addr;
    r.reg_data = data;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msp_core.sv
// play state, delay counter and stream parser with per-item result decode
`timescale 1ns / 1ps
`default_nettype none

module msp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire msp_pkg::item_t  item_i,
  input  wire logic            fire_i,
  input  wire logic [7:0]      psg_base_i,
  output msp_pkg::bundle_t     bundle_o
);

  logic [1:0] state_q, state_d;
  logic [6:0] delay_q, delay_d;
  logic       fetching_q, fetching_d;
  logic [1:0] phase_q, phase_d;
  logic [5:0] offset_q, offset_d;
  logic [5:0] pairs_q, pairs_d;
  logic [7:0] fmreg_q, fmreg_d;

  msp_pkg::res_t [msp_pkg::MAX_RES-1:0] r;
  logic [1:0] cnt;
  logic [7:0] b;

  assign b = item_i.stream_byte;

  always_comb begin
    state_d    = state_q;
    delay_d    = delay_q;
    fetching_d = fetching_q;
    phase_d    = phase_q;
    offset_d   = offset_q;
    pairs_d    = pairs_q;
    fmreg_d    = fmreg_q;
    cnt        = 2'd0;
    for (int i = 0; i < msp_pkg::MAX_RES; i++) begin
      r[i] = msp_pkg::mk_res(msp_pkg::K_SILENCE, 8'd0, 8'd0);
    end
    case (item_i.operation)
      msp_pkg::OP_BYTE: begin
        if (fetching_q) begin
          case (phase_q)
            msp_pkg::PH_CMD: begin
              if (b[7:6] == 2'b00) begin
                offset_d = b[5:0];
                phase_d  = msp_pkg::PH_SND;
                r[0]     = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
                cnt      = 2'd1;
              end else if (b[7:6] == 2'b01) begin
                pairs_d = b[5:0];
                if (b[5:0] != 6'd0) begin
                  phase_d = msp_pkg::PH_FMREG;
                end
                r[0] = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
                cnt  = 2'd1;
              end else begin
                delay_d    = b[6:0];
                fetching_d = 1'b0;
                phase_d    = msp_pkg::PH_CMD;
                if (b[6:0] == 7'd0) begin
                  r[0] = msp_pkg::mk_res(msp_pkg::K_END, 8'd0, 8'd0);
                  cnt  = 2'd1;
                  if (state_q != msp_pkg::ST_NOSONG) begin
                    state_d  = msp_pkg::ST_STOPPED;
                    delay_d  = 7'd1;
                    offset_d = 6'd0;
                    pairs_d  = 6'd0;
                    fmreg_d  = 8'd0;
                    r[1]     = msp_pkg::mk_res(msp_pkg::K_REWIND, 8'd0, 8'd0);
                    r[2]     = msp_pkg::mk_res(msp_pkg::K_SILENCE, 8'd0, 8'd0);
                    cnt      = 2'd3;
                  end
                end
              end
            end
            msp_pkg::PH_SND: begin
              r[0]    = msp_pkg::mk_res(msp_pkg::K_SND,
                                        8'(psg_base_i + {2'b00, offset_q}), b);
              r[1]    = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
              cnt     = 2'd2;
              phase_d = msp_pkg::PH_CMD;
            end
            msp_pkg::PH_FMREG: begin
              fmreg_d = b;
              phase_d = msp_pkg::PH_FMDAT;
              r[0]    = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
              cnt     = 2'd1;
            end
            default: begin
              r[0]    = msp_pkg::mk_res(msp_pkg::K_FM, fmreg_q, b);
              r[1]    = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
              cnt     = 2'd2;
              pairs_d = pairs_q - 6'd1;
              phase_d = (pairs_q != 6'd1) ? msp_pkg::PH_FMREG : msp_pkg::PH_CMD;
            end
          endcase
        end
      end
      msp_pkg::OP_TICK: begin
        if (state_q == msp_pkg::ST_PLAYING && !fetching_q) begin
          delay_d = delay_q - 7'd1;
          if (delay_q == 7'd1) begin
            fetching_d = 1'b1;
            phase_d    = msp_pkg::PH_CMD;
            r[0]       = msp_pkg::mk_res(msp_pkg::K_FETCH, 8'd0, 8'd0);
            cnt        = 2'd1;
          end
        end
      end
      msp_pkg::OP_PLAY: begin
        if (state_q != msp_pkg::ST_NOSONG) begin
          state_d = msp_pkg::ST_PLAYING;
        end
      end
      msp_pkg::OP_PAUSE: begin
        if (state_q == msp_pkg::ST_PLAYING) begin
          state_d = msp_pkg::ST_PAUSED;
          r[0]    = msp_pkg::mk_res(msp_pkg::K_SILENCE, 8'd0, 8'd0);
          cnt     = 2'd1;
        end
      end
      msp_pkg::OP_STOP: begin
        if (state_q != msp_pkg::ST_NOSONG) begin
          state_d    = msp_pkg::ST_STOPPED;
          delay_d    = 7'd1;
          fetching_d = 1'b0;
          phase_d    = msp_pkg::PH_CMD;
          offset_d   = 6'd0;
          pairs_d    = 6'd0;
          fmreg_d    = 8'd0;
          r[0]       = msp_pkg::mk_res(msp_pkg::K_REWIND, 8'd0, 8'd0);
          r[1]       = msp_pkg::mk_res(msp_pkg::K_SILENCE, 8'd0, 8'd0);
          cnt        = 2'd2;
        end
      end
      msp_pkg::OP_LOAD: begin
        if (state_q != msp_pkg::ST_NOSONG) begin
          r[0] = msp_pkg::mk_res(msp_pkg::K_REWIND, 8'd0, 8'd0);
          r[1] = msp_pkg::mk_res(msp_pkg::K_SILENCE, 8'd0, 8'd0);
          cnt  = 2'd2;
        end
        state_d    = item_i.header_valid ? msp_pkg::ST_STOPPED : msp_pkg::ST_NOSONG;
        delay_d    = 7'd1;
        fetching_d = 1'b0;
        phase_d    = msp_pkg::PH_CMD;
        offset_d   = 6'd0;
        pairs_d    = 6'd0;
        fmreg_d    = 8'd0;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < msp_pkg::MAX_RES; i++) begin
      r[i].last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
    end
  end

  assign bundle_o.cnt = cnt;
  assign bundle_o.res = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= msp_pkg::ST_NOSONG;
      delay_q    <= 7'd1;
      fetching_q <= 1'b0;
      phase_q    <= msp_pkg::PH_CMD;
      offset_q   <= 6'd0;
      pairs_q    <= 6'd0;
      fmreg_q    <= 8'd0;
    end else if (fire_i) begin
      state_q    <= state_d;
      delay_q    <= delay_d;
      fetching_q <= fetching_d;
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      pairs_q    <= pairs_d;
      fmreg_q    <= fmreg_d;
    end
  end

`ifndef ASSERT_OFF
  a_fetch_needs_song: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetching_q |-> (state_q == msp_pkg::ST_PLAYING || state_q == msp_pkg::ST_PAUSED))
    else $error("fetch active without a playing or paused song");

  a_phase_needs_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != msp_pkg::PH_CMD) |-> fetching_q)
    else $error("parser mid-command outside a fetch");

  a_fm_pairs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == msp_pkg::PH_FMREG || phase_q == msp_pkg::PH_FMDAT) |-> (pairs_q != 6'd0))
    else $error("fm phase with no pairs left");
`endif

endmodule

`default_nettype wire

FILE: rtl/msp_out.sv
// result register that hands out one result of a bundle per transfer
`timescale 1ns / 1ps
`default_nettype none

module msp_out (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  load_i,
  input  wire msp_pkg::res_t [msp_pkg::MAX_RES-1:0]  res_i,
  output logic                                       free_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output msp_pkg::res_t                              out_data_o
);

  logic                                  vld_q;
  logic [1:0]                            idx_q;
  msp_pkg::res_t [msp_pkg::MAX_RES-1:0]  res_q;
  msp_pkg::res_t                         cur;
  logic                                  take;
  logic                                  last_xfer;

  always_comb begin
    case (idx_q)
      2'd0:    cur = res_q[0];
      2'd1:    cur = res_q[1];
      default: cur = res_q[2];
    endcase
  end

  assign take        = vld_q && !out_stall_i;
  assign last_xfer   = take && cur.last;
  assign free_o      = !vld_q || last_xfer;
  assign out_valid_o = vld_q;
  assign out_data_o  = cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (last_xfer) begin
      vld_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/music_command_stream_player.sv
// top level of the music command stream player
// an item enters the input register and is decoded there; an item with results is loaded
// into the result register once free; each result transfers when the output does not stall
// throughput: one item per cycle while each item gives at most one result and the output does not stall;
// an item with n results holds the result register for n output transfers
// reset: asynchronous active low, no song loaded, psg base 0xC0, all buffers empty
`timescale 1ns / 1ps
`default_nettype none

module music_command_stream_player (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire msp_pkg::item_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output msp_pkg::res_t        out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [7:0]      cfg_data_i
);

  logic             in_vld_q;
  msp_pkg::item_t   in_q;
  logic [7:0]       psg_base_q;
  msp_pkg::bundle_t bundle;
  logic             fire;
  logic             load;
  logic             free;
  logic             accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psg_base_q <= msp_pkg::PSG_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      psg_base_q <= cfg_data_i;
    end
  end

  // an item with no results retires even while the result register is busy
  assign fire       = in_vld_q && (bundle.cnt == 2'd0 || free);
  assign load       = fire && (bundle.cnt != 2'd0);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  msp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_q),
    .fire_i     (fire),
    .psg_base_i (psg_base_q),
    .bundle_o   (bundle)
  );

  msp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (bundle.res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_bundle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=> out_valid_o)
    else $error("result bundle dropped before its last transfer");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> free)
    else $error("result register overwritten while busy");

  a_stall_means_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && bundle.cnt != 2'd0))
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire
